>>> src/lphi_pkg.sv
// Package: widths, command and status codes, and slot entry type for the hash index.
`default_nettype none
package lphi_pkg;

    localparam int SLOT_BITS  = 6;
    localparam int SLOTS      = 1 << SLOT_BITS;
    localparam int KEY_BITS   = 48;
    localparam int VALUE_BITS = 16;
    localparam int HASH_BITS  = 32;
    localparam int CMD_BITS   = 3;
    localparam int LOG2_BITS  = 3;
    localparam int COUNT_BITS = SLOT_BITS + 1;
    localparam int IN_BITS    = 112;
    localparam int OUT_BITS   = 80;

    localparam logic [LOG2_BITS-1:0] MIN_LOG2   = 3'd3;
    localparam logic [LOG2_BITS-1:0] MAX_LOG2   = 3'd6;
    localparam logic [LOG2_BITS-1:0] RESET_LOG2 = 3'd6;
    localparam logic [4:0]           MAX_MOVES  = 5'd31;

    localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_ERASE  = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_PRESENT  = 2'd2;
    localparam logic [1:0] ST_NOSPACE  = 2'd3;

    typedef struct packed {
        logic [HASH_BITS-1:0]  hash;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic [1:0]            status;
        logic                  relocated;
        logic [SLOT_BITS-1:0]  slot;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic                  last;
    } result_t;

endpackage
`default_nettype wire

>>> src/linear_probe_hash_index_core.sv
// Top level: linear-probing hash index with backward-shift erase over a slot memory.
// Clear, unused codes and erase or read misses go straight to the result; a read hit first
// fetches the slot; lookup and insert probe occupied slots until a key match or an empty
// slot; erase scans past the hole, reporting each move. A stalled sink holds each result.
// One transaction at a time: the next is taken once the final result is registered.
// Reset (aresetn low, synchronous): all slots empty, entry count zero, capacity_log2 = 6.
`default_nettype none
module linear_probe_hash_index_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [lphi_pkg::LOG2_BITS-1:0]      cfg_wr_data,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // cmd[2:0], key[50:3], key_hash[82:51], value[98:83], slot_sel[104:99], zero fill
    input  wire logic [lphi_pkg::IN_BITS-1:0]        s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // status[1:0], relocated[2], out_slot[8:3], out_key[56:9], out_value[72:57], zero fill
    output logic [lphi_pkg::OUT_BITS-1:0]            m_tdata,
    output logic                                     m_tlast
);

    localparam int SB = lphi_pkg::SLOT_BITS;
    localparam int CB = lphi_pkg::COUNT_BITS;

    typedef enum logic [7:0] {
        S_IDLE       = 8'b0000_0001,
        S_DISPATCH   = 8'b0000_0010,
        S_PROBE      = 8'b0000_0100,
        S_PROBE_CMP  = 8'b0000_1000,
        S_SLOT_FETCH = 8'b0001_0000,
        S_ER_LOOP    = 8'b0010_0000,
        S_ER_CMP     = 8'b0100_0000,
        S_EMIT       = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next, after_reg, after_next;

    logic [lphi_pkg::CMD_BITS-1:0]   cmd_reg, cmd_next;
    logic [lphi_pkg::KEY_BITS-1:0]   key_reg, key_next;
    logic [lphi_pkg::HASH_BITS-1:0]  hash_reg, hash_next;
    logic [lphi_pkg::VALUE_BITS-1:0] val_reg, val_next;
    logic [SB-1:0]                   idx_reg, idx_next;
    logic [SB-1:0]                   cur_reg, cur_next, hole_reg, hole_next;
    logic [CB-1:0]                   n_reg, n_next, count_reg, count_next;
    logic [4:0]                      k_reg, k_next;
    logic [lphi_pkg::LOG2_BITS-1:0]  log2_reg, log2_next;
    logic [lphi_pkg::KEY_BITS-1:0]   rem_key_reg, rem_key_next;
    logic [lphi_pkg::VALUE_BITS-1:0] rem_val_reg, rem_val_next;
    logic [lphi_pkg::SLOTS-1:0]      valid_reg, valid_next;
    lphi_pkg::result_t               pend_reg, pend_next, out_reg, out_next;
    logic                            out_valid_reg, out_valid_next;

    lphi_pkg::entry_t mem [lphi_pkg::SLOTS];
    lphi_pkg::entry_t rd_reg, mem_wdata;
    logic             mem_we;
    logic [SB-1:0]    mem_waddr, mem_raddr;

    logic [lphi_pkg::LOG2_BITS-1:0] lg;
    logic [CB-1:0]                  cap;
    logic [SB-1:0]                  mask, home;
    logic                           out_free, idx_bad, no_room;

    always_comb begin
        priority if (log2_reg < lphi_pkg::MIN_LOG2) begin
            lg = lphi_pkg::MIN_LOG2;
        end else if (log2_reg > lphi_pkg::MAX_LOG2) begin
            lg = lphi_pkg::MAX_LOG2;
        end else begin
            lg = log2_reg;
        end
    end

    assign cap      = CB'(1) << lg;
    assign mask     = SB'(cap - CB'(1));
    assign home     = rd_reg.hash[SB-1:0] & mask;
    assign out_free = !out_valid_reg || m_tready;
    assign idx_bad  = ({1'b0, idx_reg} >= cap) || !valid_reg[idx_reg];
    assign no_room  = ({1'b0, count_reg} * 8'd2 + 8'd2) > {1'b0, cap};

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {7'd0, out_reg.value, out_reg.key, out_reg.slot,
                       out_reg.relocated, out_reg.status};

    always_comb begin
        state_next     = state_reg;
        after_next     = after_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        hash_next      = hash_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        hole_next      = hole_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        log2_next      = cfg_wr_en ? cfg_wr_data : log2_reg;
        rem_key_next   = rem_key_reg;
        rem_val_next   = rem_val_reg;
        valid_next     = valid_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mem_we         = 1'b0;
        mem_waddr      = cur_reg;
        mem_wdata      = rd_reg;
        mem_raddr      = cur_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tdata[2:0];
                    key_next   = s_tdata[50:3];
                    hash_next  = s_tdata[82:51];
                    val_next   = s_tdata[98:83];
                    idx_next   = s_tdata[104:99];
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                mem_raddr  = idx_reg;
                pend_next  = '{status: lphi_pkg::ST_NOTFOUND, relocated: 1'b0, slot: '0,
                               key: '0, value: '0, last: 1'b1};
                after_next = S_IDLE;
                state_next = S_EMIT;
                unique case (cmd_reg)
                    lphi_pkg::CMD_LOOKUP, lphi_pkg::CMD_INSERT: begin
                        cur_next   = hash_reg[SB-1:0] & mask;
                        n_next     = '0;
                        state_next = S_PROBE;
                    end
                    lphi_pkg::CMD_ERASE, lphi_pkg::CMD_READ: begin
                        if (!idx_bad) state_next = S_SLOT_FETCH;
                    end
                    lphi_pkg::CMD_CLEAR: begin
                        valid_next       = '0;
                        count_next       = '0;
                        pend_next.status = lphi_pkg::ST_OK;
                    end
                    default: ;
                endcase
            end
            S_PROBE: begin
                if (n_reg == cap || !valid_reg[cur_reg]) begin
                    pend_next  = '{status: lphi_pkg::ST_NOTFOUND, relocated: 1'b0, slot: '0,
                                   key: '0, value: '0, last: 1'b1};
                    after_next = S_IDLE;
                    state_next = S_EMIT;
                    if (cmd_reg == lphi_pkg::CMD_INSERT) begin
                        if (no_room || n_reg == cap) begin
                            pend_next.status = lphi_pkg::ST_NOSPACE;
                        end else begin
                            // first empty slot of the chain takes the new entry
                            mem_we              = 1'b1;
                            mem_wdata           = '{hash: hash_reg, key: key_reg,
                                                    payload: val_reg};
                            valid_next[cur_reg] = 1'b1;
                            count_next          = count_reg + CB'(1);
                            pend_next           = '{status: lphi_pkg::ST_OK, relocated: 1'b0,
                                                    slot: cur_reg, key: key_reg,
                                                    value: val_reg, last: 1'b1};
                        end
                    end
                end else begin
                    state_next = S_PROBE_CMP;
                end
            end
            S_PROBE_CMP: begin
                if (rd_reg.hash == hash_reg && rd_reg.key == key_reg) begin
                    pend_next  = '{status: (cmd_reg == lphi_pkg::CMD_INSERT) ?
                                           lphi_pkg::ST_PRESENT : lphi_pkg::ST_OK,
                                   relocated: 1'b0, slot: cur_reg, key: rd_reg.key,
                                   value: rd_reg.payload, last: 1'b1};
                    after_next = S_IDLE;
                    state_next = S_EMIT;
                end else begin
                    cur_next   = (cur_reg + SB'(1)) & mask;
                    n_next     = n_reg + CB'(1);
                    state_next = S_PROBE;
                end
            end
            S_SLOT_FETCH: begin
                if (cmd_reg == lphi_pkg::CMD_READ) begin
                    pend_next  = '{status: lphi_pkg::ST_OK, relocated: 1'b0, slot: idx_reg,
                                   key: rd_reg.key, value: rd_reg.payload, last: 1'b1};
                    after_next = S_IDLE;
                    state_next = S_EMIT;
                end else begin
                    rem_key_next        = rd_reg.key;
                    rem_val_next        = rd_reg.payload;
                    valid_next[idx_reg] = 1'b0;
                    hole_next           = idx_reg;
                    cur_next            = (idx_reg + SB'(1)) & mask;
                    n_next              = '0;
                    k_next              = '0;
                    state_next          = S_ER_LOOP;
                end
            end
            S_ER_LOOP: begin
                if (n_reg == cap || !valid_reg[cur_reg]) begin
                    count_next = count_reg - CB'(1);
                    pend_next  = '{status: lphi_pkg::ST_OK, relocated: 1'b0, slot: idx_reg,
                                   key: rem_key_reg, value: rem_val_reg, last: 1'b1};
                    after_next = S_IDLE;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_ER_CMP;
                end
            end
            S_ER_CMP: begin
                cur_next   = (cur_reg + SB'(1)) & mask;
                n_next     = n_reg + CB'(1);
                state_next = S_ER_LOOP;
                // move back when the hole lies nearer the entry's home than its slot
                if (((hole_reg - home) & mask) < ((cur_reg - home) & mask)) begin
                    mem_we               = 1'b1;
                    mem_waddr            = hole_reg;
                    valid_next[hole_reg] = 1'b1;
                    valid_next[cur_reg]  = 1'b0;
                    hole_next            = cur_reg;
                    if (k_reg < lphi_pkg::MAX_MOVES) begin
                        k_next     = k_reg + 5'd1;
                        pend_next  = '{status: lphi_pkg::ST_OK, relocated: 1'b1,
                                       slot: hole_reg, key: rd_reg.key,
                                       value: rd_reg.payload, last: 1'b0};
                        after_next = S_ER_LOOP;
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = after_reg;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        rd_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            after_reg     <= S_IDLE;
            count_reg     <= '0;
            log2_reg      <= lphi_pkg::RESET_LOG2;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            after_reg     <= after_next;
            count_reg     <= count_next;
            log2_reg      <= log2_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        hash_reg    <= hash_next;
        val_reg     <= val_next;
        idx_reg     <= idx_next;
        cur_reg     <= cur_next;
        hole_reg    <= hole_next;
        n_reg       <= n_next;
        k_reg       <= k_next;
        rem_key_reg <= rem_key_next;
        rem_val_reg <= rem_val_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CB'(lphi_pkg::SLOTS / 2))
        else $error("entry count beyond half the slot store");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("new transaction taken while one is in progress");

    a_reloc_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> !m_tlast && m_tdata[1:0] == lphi_pkg::ST_OK)
        else $error("relocation result flagged as final or with bad status");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == lphi_pkg::ST_NOTFOUND ||
                     m_tdata[1:0] == lphi_pkg::ST_NOSPACE) |-> m_tdata[72:3] == '0)
        else $error("failed result carries slot contents");

    a_emit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT && out_valid_reg && !m_tready |=> state_reg == S_EMIT)
        else $error("pending result dropped while output stalled");

endmodule
`default_nettype wire
